>>> hdl/mdc_pkg.sv
`default_nettype none

package mdc_pkg;

   localparam int DATA_W  = 64;
   localparam int SHIFT_W = 7;

   localparam logic [SHIFT_W-1:0] SHIFT_LIMIT = 7'd127;

   typedef struct packed {
      logic [DATA_W-1:0]  divisor;
      logic [DATA_W-1:0]  neg_bound;
      logic [DATA_W-1:0]  pos_bound;
      logic [SHIFT_W-1:0] min_shift;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]  multiplier;
      logic               multiplier_overflow;
      logic [SHIFT_W-1:0] shift;
      logic               invalid;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MODULO,
      ST_SELECT,
      ST_REFINE
   } state_type;

endpackage

`default_nettype wire

>>> hdl/magic_divisor_constants_unit.sv
// Sequence: a start transfer runs PREP, the MODULO loop, SELECT and then REFINE, which raises the
// returned shift s up to 127 until it passes; a rejected divisor is answered from PREP without the loops.
// Throughput: one request at a time; busy stays high until the result strobe appears.
// The two remainder lanes run one bit a cycle, then the shared refinement step adds one bit a cycle.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (synchronous, active high) returns the sequencer to idle and drops rsp_valid.
`default_nettype none

module magic_divisor_constants_unit #(
   parameter int WIDTH = 64
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire mdc_pkg::req_type req_data,
   output logic                 rsp_valid,
   output mdc_pkg::rsp_type     rsp_data
);

   localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   localparam logic [WIDTH-1:0] WTOP = {1'b1, {(WIDTH-1){1'b0}}};

   mdc_pkg::state_type state_ff, state_in;

   logic [WIDTH-1:0]           d_ff, d_in;
   logic [WIDTH-1:0]           nneg_ff, nneg_in;
   logic [WIDTH-1:0]           npos_ff, npos_in;
   logic [mdc_pkg::SHIFT_W-1:0] mins_ff, mins_in;
   logic                       bad_ff, bad_in;

   logic [WIDTH-1:0]           dvn_ff, dvn_in;
   logic [WIDTH-1:0]           dvp_ff, dvp_in;
   logic [WIDTH-1:0]           remn_ff, remn_in;
   logic [WIDTH-1:0]           remp_ff, remp_in;
   logic                       belown_ff, belown_in;
   logic                       belowp_ff, belowp_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;

   logic [WIDTH-1:0]           v_ff, v_in;
   logic                       tol_ff, tol_in;
   logic [WIDTH-1:0]           c_ff, c_in;
   logic                       covf_ff, covf_in;
   logic [WIDTH-1:0]           rc_ff, rc_in;
   logic [WIDTH-1:0]           qv_ff, qv_in;
   logic                       qovf_ff, qovf_in;
   logic [WIDTH-1:0]           rv_ff, rv_in;
   logic [mdc_pkg::SHIFT_W-1:0] s_ff, s_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   mdc_pkg::rsp_type           rsp_ff, rsp_in;

   logic [WIDTH-1:0] req_d, req_nneg, req_npos, dm1, vn, vp;
   logic [WIDTH:0]   trial_n, trial_p, diff_n, diff_p, d_ext, v_ext;
   logic [WIDTH:0]   trial_c, trial_r, diff_c, diff_r;
   logic             pass;

   always_comb begin
      state_in     = state_ff;
      d_in         = d_ff;
      nneg_in      = nneg_ff;
      npos_in      = npos_ff;
      mins_in      = mins_ff;
      bad_in       = bad_ff;
      dvn_in       = dvn_ff;
      dvp_in       = dvp_ff;
      remn_in      = remn_ff;
      remp_in      = remp_ff;
      belown_in    = belown_ff;
      belowp_in    = belowp_ff;
      cnt_in       = cnt_ff;
      v_in         = v_ff;
      tol_in       = tol_ff;
      c_in         = c_ff;
      covf_in      = covf_ff;
      rc_in        = rc_ff;
      qv_in        = qv_ff;
      qovf_in      = qovf_ff;
      rv_in        = rv_ff;
      s_in         = s_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      req_d    = req_data.divisor[WIDTH-1:0];
      req_nneg = req_data.neg_bound[WIDTH-1:0];
      req_npos = req_data.pos_bound[WIDTH-1:0];
      dm1      = d_ff - WIDTH'(1);
      d_ext    = {1'b0, d_ff};
      v_ext    = {1'b0, v_ff};

      trial_n  = {remn_ff, dvn_ff[WIDTH-1]};
      trial_p  = {remp_ff, dvp_ff[WIDTH-1]};
      diff_n   = trial_n - d_ext;
      diff_p   = trial_p - d_ext;

      vn = belown_ff ? '0 : nneg_ff - remn_ff;
      vp = belowp_ff ? '0 : npos_ff - remp_ff;

      trial_c  = {rc_ff, 1'b0};
      trial_r  = {rv_ff, 1'b0};
      diff_c   = trial_c - d_ext;
      diff_r   = trial_r - v_ext;

      pass = (s_ff >= mins_ff) &&
             (qovf_ff || (rc_ff < qv_ff) ||
              ((rc_ff == qv_ff) && (tol_ff || (rv_ff != '0))));

      unique case (state_ff)
         mdc_pkg::ST_IDLE: begin
            if (start) begin
               d_in     = req_d;
               nneg_in  = req_nneg;
               npos_in  = req_npos;
               mins_in  = req_data.min_shift;
               bad_in   = (req_d < WIDTH'(3)) ||
                          ((req_d & (req_d - WIDTH'(1))) == '0) ||
                          ((req_d > req_nneg) && (req_d > req_npos));
               state_in = mdc_pkg::ST_PREP;
            end
         end
         mdc_pkg::ST_PREP: begin
            if (bad_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{multiplier: '0, multiplier_overflow: 1'b0,
                                shift: '0, invalid: 1'b1};
               state_in     = mdc_pkg::ST_IDLE;
            end else begin
               belown_in = nneg_ff < dm1;
               belowp_in = npos_ff < dm1;
               dvn_in    = nneg_ff - dm1;
               dvp_in    = npos_ff - dm1;
               remn_in   = '0;
               remp_in   = '0;
               cnt_in    = CNT_W'(WIDTH - 1);
               state_in  = mdc_pkg::ST_MODULO;
            end
         end
         mdc_pkg::ST_MODULO: begin
            remn_in = (trial_n >= d_ext) ? diff_n[WIDTH-1:0] : trial_n[WIDTH-1:0];
            remp_in = (trial_p >= d_ext) ? diff_p[WIDTH-1:0] : trial_p[WIDTH-1:0];
            dvn_in  = dvn_ff << 1;
            dvp_in  = dvp_ff << 1;
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = mdc_pkg::ST_SELECT;
            end
         end
         mdc_pkg::ST_SELECT: begin
            v_in     = (vn > vp) ? vn : vp;
            tol_in   = vn > vp;
            c_in     = WIDTH'(1);
            covf_in  = 1'b0;
            rc_in    = dm1;
            qv_in    = '0;
            qovf_in  = 1'b0;
            rv_in    = WIDTH'(1);
            s_in     = '0;
            state_in = mdc_pkg::ST_REFINE;
         end
         mdc_pkg::ST_REFINE: begin
            if (pass) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{multiplier: mdc_pkg::DATA_W'(c_ff),
                                multiplier_overflow: covf_ff,
                                shift: s_ff, invalid: 1'b0};
               state_in     = mdc_pkg::ST_IDLE;
            end else if (covf_ff || (s_ff == mdc_pkg::SHIFT_LIMIT)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{multiplier: '0, multiplier_overflow: 1'b0,
                                shift: '0, invalid: 1'b1};
               state_in     = mdc_pkg::ST_IDLE;
            end else begin
               s_in = s_ff + mdc_pkg::SHIFT_W'(1);
               if (trial_c > d_ext) begin
                  covf_in = c_ff > WTOP;
                  c_in    = (c_ff << 1) - WIDTH'(1);
                  rc_in   = diff_c[WIDTH-1:0];
               end else begin
                  covf_in = c_ff >= WTOP;
                  c_in    = c_ff << 1;
                  rc_in   = trial_c[WIDTH-1:0];
               end
               qovf_in = qv_ff >= WTOP;
               if (trial_r >= v_ext) begin
                  qv_in = (qv_ff << 1) | WIDTH'(1);
                  rv_in = diff_r[WIDTH-1:0];
               end else begin
                  qv_in = qv_ff << 1;
                  rv_in = trial_r[WIDTH-1:0];
               end
            end
         end
         default: begin
            state_in = mdc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mdc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff      <= d_in;
      nneg_ff   <= nneg_in;
      npos_ff   <= npos_in;
      mins_ff   <= mins_in;
      bad_ff    <= bad_in;
      dvn_ff    <= dvn_in;
      dvp_ff    <= dvp_in;
      remn_ff   <= remn_in;
      remp_ff   <= remp_in;
      belown_ff <= belown_in;
      belowp_ff <= belowp_in;
      cnt_ff    <= cnt_in;
      v_ff      <= v_in;
      tol_ff    <= tol_in;
      c_ff      <= c_in;
      covf_ff   <= covf_in;
      rc_ff     <= rc_in;
      qv_ff     <= qv_in;
      qovf_ff   <= qovf_in;
      rv_ff     <= rv_in;
      s_ff      <= s_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != mdc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a request in progress");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transfer did not raise busy");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.invalid) |->
         ((rsp_data.multiplier == '0) && (rsp_data.shift == '0) &&
          !rsp_data.multiplier_overflow))
      else $error("invalid result carries nonzero fields");

   a_shift_floor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.invalid) |-> (rsp_data.shift >= mins_ff))
      else $error("returned shift below the requested minimum");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
`endif

endmodule

`default_nettype wire
